/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/rlpe_pkg.sv */
// shared types and constants of the run length pair encoder
`default_nettype none

package rlpe_pkg;

    localparam int DEF_OUT_BYTE_BUDGET = 1024;
    localparam int TRIPLE_BYTES        = 3;
    localparam logic [7:0] RUN_LIMIT   = 8'd255;
    localparam int TOTAL_W             = 11;

    // result queue geometry
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0]         run_block;
        logic [7:0]         run_action;
        logic [7:0]         run_count;
        logic               end_of_list;
        logic               truncated;
        logic [TOTAL_W-1:0] total_bytes;
    } t_result;

    // push0 writes result slot 0, push1 also writes slot 1 behind it
    typedef struct packed {
        logic push0;
        logic push1;
    } t_push_ctl;

endpackage

`default_nettype wire

/* hw/rtl/rlpe_fifo.sv */
// result queue: up to two writes and one read per cycle
`default_nettype none
`include "assert_macros.svh"

module rlpe_fifo (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire rlpe_pkg::t_push_ctl      i_ctl,
    input  wire rlpe_pkg::t_result        i_res0,
    input  wire rlpe_pkg::t_result        i_res1,
    output logic [rlpe_pkg::FIFO_CW-1:0]  o_count,
    output logic                          o_valid,
    input  wire logic                     i_pop,
    output rlpe_pkg::t_result             o_res
);
    import rlpe_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp, n_wp;
    logic [FIFO_AW-1:0]   r_rp, n_rp;
    logic [FIFO_CW-1:0]   r_count, n_count;
    logic                 pop;
    logic [FIFO_CW:0]     fill_after;

    assign pop     = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_count = r_count;
    assign o_res   = r_mem[r_rp];

    always_comb begin
        n_wp    = r_wp + FIFO_AW'(i_ctl.push0) + FIFO_AW'(i_ctl.push1);
        n_rp    = r_rp + FIFO_AW'(pop);
        n_count = r_count + FIFO_CW'(i_ctl.push0) + FIFO_CW'(i_ctl.push1)
                  - FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_ctl.push1) begin
            r_mem[r_wp + FIFO_AW'(1)] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    assign fill_after = (FIFO_CW + 1)'(r_count) + (FIFO_CW + 1)'(i_ctl.push0)
                        + (FIFO_CW + 1)'(i_ctl.push1);

    `ASSERT_ALWAYS(a_count_in_range, i_clk, i_rst_n,
        r_count <= FIFO_CW'(FIFO_DEPTH), "result queue count beyond depth")
    `ASSERT_ALWAYS(a_push_order, i_clk, i_rst_n,
        !i_ctl.push1 || i_ctl.push0, "second slot written without first")
    `ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n,
        fill_after <= (FIFO_CW + 1)'(FIFO_DEPTH), "result queue overflow")

endmodule

`default_nettype wire

/* hw/rtl/rlpe_core.sv */
// input register, run state and the per-pair encode step
`default_nettype none
`include "assert_macros.svh"

module rlpe_core #(
    parameter int OUT_BYTE_BUDGET = rlpe_pkg::DEF_OUT_BYTE_BUDGET
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_blk_id,
    input  wire logic [7:0]           i_action,
    input  wire logic                 i_last,
    output logic                      o_busy,
    output rlpe_pkg::t_push_ctl       o_ctl,
    output rlpe_pkg::t_result         o_res0,
    output rlpe_pkg::t_result         o_res1
);
    import rlpe_pkg::*;

    // a triple fits while 3 * (written + 1) < budget
    localparam int MAX_TRIPLES = (OUT_BYTE_BUDGET - 1) / TRIPLE_BYTES;
    localparam int TW_W        = $clog2(MAX_TRIPLES + 1);
    localparam logic [TW_W-1:0] MAX_TW = TW_W'(MAX_TRIPLES);

    function automatic logic [TOTAL_W-1:0] byte_total(input logic [TW_W-1:0] tw);
        logic [TW_W+1:0]         prod;
        logic [TW_W+TOTAL_W+1:0] ext;
        prod = (TW_W + 2)'(tw) + {1'b0, tw, 1'b0};
        ext  = (TW_W + TOTAL_W + 2)'(prod);
        return ext[TOTAL_W-1:0];
    endfunction

    logic            r_in_valid;
    logic [7:0]      r_in_block, r_in_action;
    logic            r_in_last;

    logic            r_run_open, n_run_open;
    logic [7:0]      r_held_block, n_held_block;
    logic [7:0]      r_held_action, n_held_action;
    logic [7:0]      r_held_count, n_held_count;
    logic [TW_W-1:0] r_tw, n_tw;
    logic            r_dropped, n_dropped;

    logic            same, close0, emit0, room1, emit_f;
    logic [TW_W-1:0] tw1, tw2;
    logic            dropped1;
    logic [7:0]      hb, ha, hc;
    t_result         res_prev, res_final;

    assign o_busy = r_in_valid;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_in_block  <= i_blk_id;
            r_in_action <= i_action;
            r_in_last   <= i_last;
        end
    end

    always_comb begin
        same   = r_run_open && (r_in_block == r_held_block)
                 && (r_in_action == r_held_action) && (r_held_count != RUN_LIMIT);
        close0 = r_run_open && !same;
        emit0  = close0 && (r_tw < MAX_TW);
        tw1    = r_tw + TW_W'(emit0);
        dropped1 = r_dropped || (close0 && !emit0);

        hb = same ? r_held_block  : r_in_block;
        ha = same ? r_held_action : r_in_action;
        hc = same ? r_held_count + 8'd1 : 8'd1;

        room1  = (tw1 < MAX_TW);
        emit_f = r_in_last && room1;
        tw2    = tw1 + TW_W'(emit_f);

        res_prev             = '0;
        res_prev.run_block   = r_held_block;
        res_prev.run_action  = r_held_action;
        res_prev.run_count   = r_held_count;

        res_final             = '0;
        res_final.end_of_list = 1'b1;
        if (room1) begin
            res_final.run_block   = hb;
            res_final.run_action  = ha;
            res_final.run_count   = hc;
            res_final.truncated   = dropped1;
            res_final.total_bytes = byte_total(tw2);
        end else begin
            // final run dropped: bare end marker
            res_final.truncated   = 1'b1;
            res_final.total_bytes = byte_total(tw1);
        end

        o_ctl.push0 = r_in_valid && (emit0 || r_in_last);
        o_ctl.push1 = r_in_valid && emit0 && r_in_last;
        o_res0      = emit0 ? res_prev : res_final;
        o_res1      = res_final;

        n_run_open    = r_run_open;
        n_held_block  = r_held_block;
        n_held_action = r_held_action;
        n_held_count  = r_held_count;
        n_tw          = r_tw;
        n_dropped     = r_dropped;
        if (r_in_valid) begin
            if (r_in_last) begin
                n_run_open    = 1'b0;
                n_held_block  = '0;
                n_held_action = '0;
                n_held_count  = '0;
                n_tw          = '0;
                n_dropped     = 1'b0;
            end else begin
                n_run_open    = 1'b1;
                n_held_block  = hb;
                n_held_action = ha;
                n_held_count  = hc;
                n_tw          = tw1;
                n_dropped     = dropped1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_run_open    <= 1'b0;
            r_held_block  <= '0;
            r_held_action <= '0;
            r_held_count  <= '0;
            r_tw          <= '0;
            r_dropped     <= 1'b0;
        end else begin
            r_in_valid    <= i_accept;
            r_run_open    <= n_run_open;
            r_held_block  <= n_held_block;
            r_held_action <= n_held_action;
            r_held_count  <= n_held_count;
            r_tw          <= n_tw;
            r_dropped     <= n_dropped;
        end
    end

    `ASSERT_ALWAYS(a_open_run_counted, i_clk, i_rst_n,
        !r_run_open || (r_held_count != 8'd0), "open run with zero count")
    `ASSERT_ALWAYS(a_budget_kept, i_clk, i_rst_n,
        r_tw <= MAX_TW, "triple count beyond byte budget")
    `ASSERT_NEXT(a_list_end_clears, i_clk, i_rst_n,
        r_in_valid && r_in_last, !r_run_open && (r_tw == '0) && !r_dropped,
        "list state not cleared after end of list")

endmodule

`default_nettype wire

/* hw/rtl/run_length_pair_encoder.sv */
// top level of the run length pair encoder
//
//  channel   dir  handshake                  payload
//  s         in   i_s_tvalid / o_s_tready    tdata blk_id, action; tlast last
//  m         out  o_m_tvalid / i_m_tready    tdata run_block, run_action,
//                                            run_count, total_bytes;
//                                            tlast end_of_list; tuser truncated
//
// a pair is taken into the input register, in the following cycle the encode step
// updates the run state and writes 0, 1 or 2 results into an 8-beat queue
// a pair passes the input register, and its results the queue, before m takes them
// one pair per cycle sustained while i_m_tready holds and pairs close at most one
// run each; a pair that closes a run and ends the list makes 2 beats, bound by
// the single output beat per cycle
// o_s_tready drops when queue occupancy plus room reserved for the pair in
// the input register would leave no space for 2 more beats, and during reset
// i_rst_n (synchronous, active low) clears run state and queue
`default_nettype none

module run_length_pair_encoder #(
    parameter int OUT_BYTE_BUDGET = rlpe_pkg::DEF_OUT_BYTE_BUDGET
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [7:0] blk_id, [15:8] action
    input  wire logic        i_s_tlast,   // last
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // [7:0] run_block, [15:8] run_action,
                                          // [23:16] run_count, [34:24] total_bytes
    output logic             o_m_tlast,   // end_of_list
    output logic             o_m_tuser    // truncated
);
    import rlpe_pkg::*;

    logic                accept;
    logic                busy;
    t_push_ctl           ctl;
    t_result             res0, res1, head;
    logic [FIFO_CW-1:0]  count;
    logic [FIFO_CW:0]    reserved;

    // keep two free slots for the pair in flight and two for the next one
    assign reserved   = (FIFO_CW + 1)'(count) + (FIFO_CW + 1)'({busy, 1'b0});
    assign o_s_tready = i_rst_n && (reserved <= (FIFO_CW + 1)'(FIFO_DEPTH - 2));
    assign accept     = i_s_tvalid && o_s_tready;

    rlpe_core #(
        .OUT_BYTE_BUDGET (OUT_BYTE_BUDGET)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_blk_id   (i_s_tdata[7:0]),
        .i_action   (i_s_tdata[15:8]),
        .i_last     (i_s_tlast),
        .o_busy     (busy),
        .o_ctl      (ctl),
        .o_res0     (res0),
        .o_res1     (res1)
    );

    rlpe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_count (count),
        .o_valid (o_m_tvalid),
        .i_pop   (i_m_tready),
        .o_res   (head)
    );

    // pack the head beat, zero fill up to whole bytes
    assign o_m_tdata = {5'b0, head.total_bytes, head.run_count,
                        head.run_action, head.run_block};
    assign o_m_tlast = head.end_of_list;
    assign o_m_tuser = head.truncated;

endmodule

`default_nettype wire
